// ===== design/midpoint_line_rasterizer_core_assert.svh =====
// Assertion macros shared by the midpoint line rasterizer modules.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef MIDPOINT_LINE_RASTERIZER_CORE_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_CORE_ASSERT_SVH

// Antecedent and consequent checked in the same cycle.
`define MLR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mlr_pkg.sv =====
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; used by mlr_setup, mlr_step and the top level.
package mlr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int PIX_BITS       = 13;
	localparam int NEAR_END       = 6;
	localparam int OUT_TDATA_W    = ((2 * PIX_BITS + 7) / 8) * 8;

	// Position of an item's result within a thick step.
	localparam logic [1:0] SLOT_SIDE_FIRST  = 2'd0;
	localparam logic [1:0] SLOT_SIDE_SECOND = 2'd1;

	typedef logic signed [PIX_BITS-1:0] pix_t;

	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SLOPE_SHALLOW_UP = 2'd0,
		SLOPE_STEEP_UP   = 2'd1,
		SLOPE_SHALLOW_DN = 2'd2,
		SLOPE_STEEP_DN   = 2'd3
	} slope_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_LINE  = 2'd1,
		KIND_SIDE  = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	typedef struct packed {
		logic more;   // major axis has not reached the end yet
		logic wide;   // side pixels go out before the line pixel
		logic last;   // current result is the final one of the step
	} step_ctl_t;

endpackage

// ===== design/mlr_setup.sv =====
// Begin-item setup: slope case selection, endpoint swap and midpoint terms.
// Depends on mlr_pkg.
module mlr_setup #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] x1,
	input  logic signed [COORD_BITS-1:0] y1,
	input  logic signed [COORD_BITS-1:0] x2,
	input  logic signed [COORD_BITS-1:0] y2,
	output logic signed [COORD_BITS:0]   start_x,
	output logic signed [COORD_BITS:0]   start_y,
	output logic signed [COORD_BITS-1:0] stop_x,
	output logic signed [COORD_BITS-1:0] stop_y,
	output mlr_pkg::slope_t              slope,
	output logic signed [COORD_BITS+3:0] decision,
	output logic signed [COORD_BITS+3:0] incr_straight,
	output logic signed [COORD_BITS+3:0] incr_diagonal
);

	localparam int DW   = COORD_BITS + 1;
	localparam int DecW = COORD_BITS + 4;

	logic signed [DW-1:0]   dx, dy, sdx, sdy;
	logic signed [DW:0]     sum;
	logic                   swap;
	logic signed [DecW-1:0] ex, ey;

	assign dx  = DW'(x2) - DW'(x1);
	assign dy  = DW'(y2) - DW'(y1);
	assign sum = (DW+1)'(dx) + (DW+1)'(dy);

	always_comb begin
		swap  = 1'b0;
		slope = mlr_pkg::SLOPE_SHALLOW_UP;
		unique case ({y1 < y2, dx[DW-1]})
			2'b10: begin
				if (dy <= dx) slope = mlr_pkg::SLOPE_SHALLOW_UP;
				else          slope = mlr_pkg::SLOPE_STEEP_UP;
			end
			2'b11: begin
				swap = 1'b1;
				if (!sum[DW]) slope = mlr_pkg::SLOPE_STEEP_DN;
				else          slope = mlr_pkg::SLOPE_SHALLOW_DN;
			end
			2'b00: begin
				if (sum[DW] || sum == '0) slope = mlr_pkg::SLOPE_STEEP_DN;
				else                      slope = mlr_pkg::SLOPE_SHALLOW_DN;
			end
			default: begin
				swap = 1'b1;
				if (dy <= dx) slope = mlr_pkg::SLOPE_STEEP_UP;
				else          slope = mlr_pkg::SLOPE_SHALLOW_UP;
			end
		endcase
	end

	// Swapping the endpoints negates both deltas.
	assign sdx = swap ? -dx : dx;
	assign sdy = swap ? -dy : dy;
	assign ex  = DecW'(sdx);
	assign ey  = DecW'(sdy);

	assign start_x = swap ? DW'(x2) : DW'(x1);
	assign start_y = swap ? DW'(y2) : DW'(y1);
	assign stop_x  = swap ? x1 : x2;
	assign stop_y  = swap ? y1 : y2;

	always_comb begin
		unique case (slope)
			mlr_pkg::SLOPE_SHALLOW_UP: begin
				decision      = ex - (ey <<< 1);
				incr_straight = -(ey <<< 1);
				incr_diagonal = (ex - ey) <<< 1;
			end
			mlr_pkg::SLOPE_STEEP_UP: begin
				decision      = ey - (ex <<< 1);
				incr_straight = -(ex <<< 1);
				incr_diagonal = (ey - ex) <<< 1;
			end
			mlr_pkg::SLOPE_SHALLOW_DN: begin
				decision      = ex + (ey <<< 1);
				incr_straight = ey <<< 1;
				incr_diagonal = (ex + ey) <<< 1;
			end
			default: begin
				decision      = -ey - (ex <<< 1);
				incr_straight = -(ex <<< 1);
				incr_diagonal = (-ey - ex) <<< 1;
			end
		endcase
	end

endmodule

// ===== design/mlr_step.sv =====
// Step-item logic: end test, decision update, side and line pixel selection.
// Depends on mlr_pkg.
module mlr_step #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS:0]   pos_x,
	input  logic signed [COORD_BITS:0]   pos_y,
	input  logic signed [COORD_BITS-1:0] stop_x,
	input  logic signed [COORD_BITS-1:0] stop_y,
	input  logic signed [COORD_BITS+3:0] decision,
	input  logic signed [COORD_BITS+3:0] incr_straight,
	input  logic signed [COORD_BITS+3:0] incr_diagonal,
	input  mlr_pkg::slope_t              slope,
	input  logic                         thick_mode,
	input  logic [1:0]                   slot,
	output mlr_pkg::step_ctl_t           ctl,
	output mlr_pkg::pix_t                pix_x,
	output mlr_pkg::pix_t                pix_y,
	output mlr_pkg::kind_t               kind,
	output logic signed [COORD_BITS:0]   next_pos_x,
	output logic signed [COORD_BITS:0]   next_pos_y,
	output logic signed [COORD_BITS+3:0] next_decision
);

	localparam int PW = COORD_BITS + 2;
	localparam logic signed [PW-1:0] ONE     = PW'(1);
	localparam logic signed [PW-1:0] NEAR_PW = PW'(mlr_pkg::NEAR_END);

	logic signed [PW-1:0] px, py, sx, sy, remain;
	logic signed [PW-1:0] mx, my, lx, ly, minor;
	logic signed [PW-1:0] side_a, side_b, sel_side;
	logic signed [PW-1:0] side_x, side_y;
	logic                 more, diag, wide, a_neg, shallow;

	assign px = PW'(pos_x);
	assign py = PW'(pos_y);
	assign sx = PW'(stop_x);
	assign sy = PW'(stop_y);

	always_comb begin
		more   = 1'b0;
		remain = '0;
		unique case (slope) inside
			mlr_pkg::SLOPE_SHALLOW_UP, mlr_pkg::SLOPE_SHALLOW_DN: begin
				more   = px < sx;
				remain = sx - px;
			end
			mlr_pkg::SLOPE_STEEP_UP: begin
				more   = py < sy;
				remain = sy - py;
			end
			default: begin
				more   = sy < py;
				remain = py - sy;
			end
		endcase
	end

	// A tie takes the diagonal move.
	assign diag    = decision[COORD_BITS+3] || decision == '0;
	assign wide    = thick_mode && remain > NEAR_PW;
	assign shallow = slope == mlr_pkg::SLOPE_SHALLOW_UP || slope == mlr_pkg::SLOPE_SHALLOW_DN;
	assign next_decision = decision + (diag ? incr_diagonal : incr_straight);

	// Minor-axis move first, then the major-axis move for the line pixel.
	always_comb begin
		mx    = px;
		my    = py;
		lx    = px;
		ly    = py;
		a_neg = diag;
		unique case (slope)
			mlr_pkg::SLOPE_SHALLOW_UP: begin
				if (diag) my = py + ONE;
				lx = px + ONE;
				ly = my;
			end
			mlr_pkg::SLOPE_SHALLOW_DN: begin
				if (diag) my = py - ONE;
				a_neg = 1'b0;
				lx = px + ONE;
				ly = my;
			end
			mlr_pkg::SLOPE_STEEP_UP: begin
				if (diag) mx = px + ONE;
				lx = mx;
				ly = py + ONE;
			end
			default: begin
				if (diag) mx = px + ONE;
				lx = mx;
				ly = py - ONE;
			end
		endcase
	end

	assign minor    = shallow ? my : mx;
	assign side_a   = a_neg ? minor - ONE : minor + ONE;
	assign side_b   = a_neg ? minor + ONE : minor - ONE;
	assign sel_side = (slot == mlr_pkg::SLOT_SIDE_FIRST) ? side_a : side_b;
	assign side_x   = shallow ? mx : sel_side;
	assign side_y   = shallow ? sel_side : my;

	assign next_pos_x = (COORD_BITS+1)'(lx);
	assign next_pos_y = (COORD_BITS+1)'(ly);

	always_comb begin
		ctl.more = more;
		ctl.wide = wide;
		ctl.last = 1'b1;
		if (!more) begin
			pix_x = mlr_pkg::pix_t'(stop_x);
			pix_y = mlr_pkg::pix_t'(stop_y);
			kind  = mlr_pkg::KIND_END;
		end else if (wide && (slot == mlr_pkg::SLOT_SIDE_FIRST ||
				slot == mlr_pkg::SLOT_SIDE_SECOND)) begin
			pix_x    = mlr_pkg::pix_t'(side_x);
			pix_y    = mlr_pkg::pix_t'(side_y);
			kind     = mlr_pkg::KIND_SIDE;
			ctl.last = 1'b0;
		end else begin
			pix_x = mlr_pkg::pix_t'(lx);
			pix_y = mlr_pkg::pix_t'(ly);
			kind  = mlr_pkg::KIND_LINE;
		end
	end

endmodule

// ===== design/midpoint_line_rasterizer_core.sv =====
// Midpoint line rasterizer top level: input register, line state, result register.
// Depends on mlr_pkg, mlr_setup, mlr_step and midpoint_line_rasterizer_core_assert.svh.
//
//   channel     | signals                              | payload
//   ------------+--------------------------------------+--------------------------------
//   input       | s_tvalid s_tready s_tdata s_tuser    | endpoints; tuser = operation
//   result      | m_tvalid m_tready m_tdata m_tuser    | pixel x/y; kind, line_done
//               | m_tlast                              | final result of an input item
//   thick_mode  | thick_mode_we thick_mode_wdata       | side pixel enable
//
// One result per cycle while m_tready is high. A begin item and a plain step each
// give one result from the input register; a thick step far from the end holds it
// for two side pixels, then the line pixel. A step while no line is active leaves with no result.
// Reset clears the control state only; no clearing pass is needed.
// m_tready low holds the result register and, through it, the input register.
module midpoint_line_rasterizer_core #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               thick_mode_we,
	input  logic                               thick_mode_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// start_x, start_y, end_x, end_y from bit 0 up, zero padded to bytes
	input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// operation
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pixel_x, pixel_y from bit 0 up, zero padded to bytes
	output logic [mlr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// pixel_kind, line_done from bit 0 up
	output logic [2:0]                         m_tuser,
	output logic                               m_tlast
);

	localparam int C = COORD_BITS;

	// Input register
	logic                 valid_s1;
	mlr_pkg::op_t         op_s1;
	logic [4*C-1:0]       coords_s1;
	logic [1:0]           slot_q;

	// Line state
	logic signed [C:0]    pos_x_q, pos_y_q;
	logic signed [C-1:0]  stop_x_q, stop_y_q;
	logic signed [C+3:0]  decision_q, incr_straight_q, incr_diagonal_q;
	mlr_pkg::slope_t      slope_q;
	logic                 line_active_q;
	logic                 thick_q;

	// Result register
	logic                 m_valid_q;
	mlr_pkg::pix_t        pix_x_q, pix_y_q;
	mlr_pkg::kind_t       kind_q;
	logic                 last_q;

	// Setup outputs
	logic signed [C:0]    su_start_x, su_start_y;
	logic signed [C-1:0]  su_stop_x, su_stop_y;
	mlr_pkg::slope_t      su_slope;
	logic signed [C+3:0]  su_decision, su_incr_straight, su_incr_diagonal;

	// Step outputs
	mlr_pkg::step_ctl_t   step_ctl;
	mlr_pkg::pix_t        st_pix_x, st_pix_y;
	mlr_pkg::kind_t       st_kind;
	logic signed [C:0]    st_next_x, st_next_y;
	logic signed [C+3:0]  st_next_decision;

	logic                 is_step, idle_step, out_free, emit, item_last, retire, s_acc;
	mlr_pkg::pix_t        res_x, res_y;
	mlr_pkg::kind_t       res_kind;

	mlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.x1            (coords_s1[C-1:0]),
		.y1            (coords_s1[2*C-1:C]),
		.x2            (coords_s1[3*C-1:2*C]),
		.y2            (coords_s1[4*C-1:3*C]),
		.start_x       (su_start_x),
		.start_y       (su_start_y),
		.stop_x        (su_stop_x),
		.stop_y        (su_stop_y),
		.slope         (su_slope),
		.decision      (su_decision),
		.incr_straight (su_incr_straight),
		.incr_diagonal (su_incr_diagonal)
	);

	mlr_step #(.COORD_BITS(COORD_BITS)) u_step (
		.pos_x         (pos_x_q),
		.pos_y         (pos_y_q),
		.stop_x        (stop_x_q),
		.stop_y        (stop_y_q),
		.decision      (decision_q),
		.incr_straight (incr_straight_q),
		.incr_diagonal (incr_diagonal_q),
		.slope         (slope_q),
		.thick_mode    (thick_q),
		.slot          (slot_q),
		.ctl           (step_ctl),
		.pix_x         (st_pix_x),
		.pix_y         (st_pix_y),
		.kind          (st_kind),
		.next_pos_x    (st_next_x),
		.next_pos_y    (st_next_y),
		.next_decision (st_next_decision)
	);

	assign is_step   = op_s1 == mlr_pkg::OP_STEP;
	assign idle_step = is_step && !line_active_q;
	assign out_free  = !m_valid_q || m_tready;
	assign emit      = valid_s1 && !idle_step && out_free;
	assign item_last = is_step ? step_ctl.last : 1'b1;
	// Drop an idle step at once; otherwise retire on the item's final transfer.
	assign retire    = valid_s1 && (idle_step || (emit && item_last));
	assign s_tready  = !valid_s1 || retire;
	assign s_acc     = s_tvalid && s_tready;

	assign res_x    = is_step ? st_pix_x : mlr_pkg::pix_t'(su_start_x);
	assign res_y    = is_step ? st_pix_y : mlr_pkg::pix_t'(su_start_y);
	assign res_kind = is_step ? st_kind : mlr_pkg::KIND_START;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			slot_q        <= mlr_pkg::SLOT_SIDE_FIRST;
			line_active_q <= 1'b0;
			thick_q       <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			if (thick_mode_we) thick_q <= thick_mode_wdata;

			if (s_acc)       valid_s1 <= 1'b1;
			else if (retire) valid_s1 <= 1'b0;

			if (retire)    slot_q <= mlr_pkg::SLOT_SIDE_FIRST;
			else if (emit) slot_q <= slot_q + 2'd1;

			if (retire && !is_step)                        line_active_q <= 1'b1;
			else if (retire && !idle_step && !step_ctl.more) line_active_q <= 1'b0;

			if (emit)          m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1     <= mlr_pkg::op_t'(s_tuser);
			coords_s1 <= s_tdata[4*C-1:0];
		end
		if (retire && !is_step) begin
			pos_x_q         <= su_start_x;
			pos_y_q         <= su_start_y;
			stop_x_q        <= su_stop_x;
			stop_y_q        <= su_stop_y;
			slope_q         <= su_slope;
			decision_q      <= su_decision;
			incr_straight_q <= su_incr_straight;
			incr_diagonal_q <= su_incr_diagonal;
		end else if (retire && !idle_step && step_ctl.more) begin
			pos_x_q    <= st_next_x;
			pos_y_q    <= st_next_y;
			decision_q <= st_next_decision;
		end
		if (emit) begin
			pix_x_q <= res_x;
			pix_y_q <= res_y;
			kind_q  <= res_kind;
			last_q  <= item_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = mlr_pkg::OUT_TDATA_W'({pix_y_q, pix_x_q});
	assign m_tuser  = {kind_q == mlr_pkg::KIND_END, kind_q};
	assign m_tlast  = last_q;

`include "midpoint_line_rasterizer_core_assert.svh"

	`MLR_ASSERT_NEXT(a_emit_loads_out, emit, m_valid_q, "result transfer lost")
	`MLR_ASSERT_NEXT(a_end_closes_line, emit && res_kind == mlr_pkg::KIND_END,
		!line_active_q, "line still active after end pixel")
	`MLR_ASSERT_NEXT(a_begin_opens_line, retire && !is_step, line_active_q,
		"begin did not start a line")
	`MLR_ASSERT_SAME(a_slot_only_wide, slot_q != mlr_pkg::SLOT_SIDE_FIRST,
		valid_s1 && is_step && step_ctl.wide, "side slot advanced outside a thick step")

endmodule

// ===== tb/tb_midpoint_line_rasterizer_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for midpoint_line_rasterizer_core: directed table, then random lines.
// Depends on mlr_pkg and the core RTL; expected pixels come from an in-bench line stepper.
module tb_midpoint_line_rasterizer_core;

	localparam int CB           = mlr_pkg::COORD_BITS_DEF;
	localparam int IN_TDATA_W   = ((4 * CB + 7) / 8) * 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_WAIT  = 8;
	localparam int SINK_HOLD    = 300;
	localparam int DIR_ROWS     = 24;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 60;
	localparam int MAX_REPORTS  = 30;

	typedef struct packed {
		mlr_pkg::pix_t  x;
		mlr_pkg::pix_t  y;
		mlr_pkg::kind_t kind;
		logic           last;
		logic           done;
	} pixel_rec_t;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_THICK_ON,
		ROW_THICK_OFF
	} row_act_t;

	typedef enum logic [1:0] {
		EXP_MODEL,   // expectation from the line stepper
		EXP_NONE,    // item must produce nothing
		EXP_ONE      // single pixel typed into the row
	} exp_mode_t;

	typedef struct packed {
		row_act_t       act;
		mlr_pkg::op_t   op;
		int             sx;
		int             sy;
		int             ex;
		int             ey;
		exp_mode_t      mode;
		int             tx;
		int             ty;
		mlr_pkg::kind_t tk;
	} stim_row_t;

	logic                  clk              = 1'b0;
	logic                  arst_n           = 1'b0;
	logic                  thick_mode_we    = 1'b0;
	logic                  thick_mode_wdata = 1'b0;
	logic                  s_tvalid         = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata          = '0;
	logic                  s_tuser          = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready         = 1'b0;
	logic [mlr_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;

	// line stepper state
	int              cur_x, cur_y, dst_x, dst_y;
	int              dec, inc_str, inc_dia;
	mlr_pkg::slope_t slope;
	bit              line_on;
	bit              thick_on;

	pixel_rec_t step_out[$];
	pixel_rec_t pixel_q[$];

	int  cycle_cnt       = 0;
	int  errors          = 0;
	int  results_checked = 0;
	int  items_used      = 0;
	int  lines_begun     = 0;
	int  thick_writes    = 0;
	int  src_quiet_left  = 0;
	bit  src_quiet       = 0;
	bit  tail_phase      = 0;

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_NONE,      0,     0, mlr_pkg::KIND_START},
		'{ROW_ITEM,      mlr_pkg::OP_BEGIN,     0,     0,     0,     0,
			EXP_ONE,       0,     0, mlr_pkg::KIND_START},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_ONE,       0,     0, mlr_pkg::KIND_END},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,     -1,    -1,    -1,    -1,
			EXP_NONE,      0,     0, mlr_pkg::KIND_START},
		'{ROW_ITEM,      mlr_pkg::OP_BEGIN, -2048, -2048,  2047,  2047,
			EXP_ONE,   -2048, -2048, mlr_pkg::KIND_START},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,     -1,    -1,    -1,    -1,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_THICK_ON,  mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_BEGIN,  2047, -2048, -2048,  2047,
			EXP_ONE,   -2048,  2047, mlr_pkg::KIND_START},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_BEGIN,  2047,  2047, -2048, -2048,
			EXP_ONE,   -2048, -2048, mlr_pkg::KIND_START},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_BEGIN, -2048,  2047,  2047,  2047,
			EXP_ONE,   -2048,  2047, mlr_pkg::KIND_START},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_BEGIN,    10,     5,     3,     1,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_START},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_THICK_OFF, mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_STEP,      0,     0,     0,     0,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_LINE},
		'{ROW_ITEM,      mlr_pkg::OP_BEGIN,     0,     0,     3,    -5,
			EXP_MODEL,     0,     0, mlr_pkg::KIND_START}
	};

	midpoint_line_rasterizer_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.thick_mode_we    (thick_mode_we),
		.thick_mode_wdata (thick_mode_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.m_tlast          (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt, pixel_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
	endtask

	function automatic void emit(input int x, input int y, input mlr_pkg::kind_t k,
			input bit done);
		pixel_rec_t r;
		r.x    = mlr_pkg::pix_t'(x);
		r.y    = mlr_pkg::pix_t'(y);
		r.kind = k;
		r.last = 1'b0;
		r.done = done;
		step_out.push_back(r);
	endfunction

	function automatic void line_setup(input int x1, input int y1, input int x2, input int y2,
			input mlr_pkg::slope_t sc);
		int dx, dy;
		dx = x2 - x1;
		dy = y2 - y1;
		cur_x = x1;
		cur_y = y1;
		dst_x = x2;
		dst_y = y2;
		slope = sc;
		case (sc)
			mlr_pkg::SLOPE_SHALLOW_UP: begin
				dec = dx - 2 * dy; inc_str = -2 * dy; inc_dia = 2 * (dx - dy);
			end
			mlr_pkg::SLOPE_STEEP_UP: begin
				dec = dy - 2 * dx; inc_str = -2 * dx; inc_dia = 2 * (dy - dx);
			end
			mlr_pkg::SLOPE_SHALLOW_DN: begin
				dec = dx + 2 * dy; inc_str = 2 * dy; inc_dia = 2 * (dx + dy);
			end
			default: begin
				dec = -dy - 2 * dx; inc_str = -2 * dx; inc_dia = 2 * (-dy - dx);
			end
		endcase
		line_on = 1'b1;
	endfunction

	// Fill step_out with the pixels one accepted transfer produces.
	function automatic void rasterize_item(input mlr_pkg::op_t op, input int x1, input int y1,
			input int x2, input int y2);
		int  dx, dy, remain, a;
		bit  more, diag, wide;
		step_out.delete();
		if (op == mlr_pkg::OP_BEGIN) begin
			dx = x2 - x1;
			dy = y2 - y1;
			lines_begun++;
			// swap endpoints where needed so stepping always runs forward
			if (y1 < y2) begin
				if (dx >= 0) begin
					if (dy <= dx) line_setup(x1, y1, x2, y2, mlr_pkg::SLOPE_SHALLOW_UP);
					else line_setup(x1, y1, x2, y2, mlr_pkg::SLOPE_STEEP_UP);
				end else begin
					if (-dx <= dy) line_setup(x2, y2, x1, y1, mlr_pkg::SLOPE_STEEP_DN);
					else line_setup(x2, y2, x1, y1, mlr_pkg::SLOPE_SHALLOW_DN);
				end
			end else begin
				if (dx >= 0) begin
					if (dx <= -dy) line_setup(x1, y1, x2, y2, mlr_pkg::SLOPE_STEEP_DN);
					else line_setup(x1, y1, x2, y2, mlr_pkg::SLOPE_SHALLOW_DN);
				end else begin
					if (-dx <= -dy) line_setup(x2, y2, x1, y1, mlr_pkg::SLOPE_STEEP_UP);
					else line_setup(x2, y2, x1, y1, mlr_pkg::SLOPE_SHALLOW_UP);
				end
			end
			emit(cur_x, cur_y, mlr_pkg::KIND_START, 1'b0);
		end else begin
			if (!line_on)
				return;
			case (slope)
				mlr_pkg::SLOPE_SHALLOW_UP, mlr_pkg::SLOPE_SHALLOW_DN: begin
					more = cur_x < dst_x; remain = dst_x - cur_x;
				end
				mlr_pkg::SLOPE_STEEP_UP: begin
					more = cur_y < dst_y; remain = dst_y - cur_y;
				end
				default: begin
					more = dst_y < cur_y; remain = cur_y - dst_y;
				end
			endcase
			if (!more) begin
				emit(dst_x, dst_y, mlr_pkg::KIND_END, 1'b1);
				line_on = 1'b0;
			end else begin
				diag = dec <= 0;
				wide = thick_on && remain > mlr_pkg::NEAR_END;
				dec += diag ? inc_dia : inc_str;
				if (slope == mlr_pkg::SLOPE_SHALLOW_UP || slope == mlr_pkg::SLOPE_SHALLOW_DN) begin
					if (diag) cur_y += (slope == mlr_pkg::SLOPE_SHALLOW_UP) ? 1 : -1;
					if (wide) begin
						a = (slope == mlr_pkg::SLOPE_SHALLOW_UP && diag) ? -1 : 1;
						emit(cur_x, cur_y + a, mlr_pkg::KIND_SIDE, 1'b0);
						emit(cur_x, cur_y - a, mlr_pkg::KIND_SIDE, 1'b0);
					end
					cur_x += 1;
				end else begin
					if (diag) cur_x += 1;
					if (wide) begin
						a = diag ? -1 : 1;
						emit(cur_x + a, cur_y, mlr_pkg::KIND_SIDE, 1'b0);
						emit(cur_x - a, cur_y, mlr_pkg::KIND_SIDE, 1'b0);
					end
					cur_y += (slope == mlr_pkg::SLOPE_STEEP_UP) ? 1 : -1;
				end
				emit(cur_x, cur_y, mlr_pkg::KIND_LINE, 1'b0);
			end
		end
		step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	function automatic int pick_gap();
		if (src_quiet_left == 0) begin
			src_quiet = $urandom_range(0, 3) == 0;
			src_quiet_left = $urandom_range(20, 80);
		end else begin
			src_quiet_left--;
		end
		if (src_quiet || $urandom_range(0, 99) < 65)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic int near_coord(input int c, input int span);
		int d;
		d = $urandom_range(0, span);
		if ($urandom_range(0, 1) == 1) d = -d;
		if (c + d > 2047 || c + d < -2048) d = -d;
		return c + d;
	endfunction

	// Offer one transfer, wait for it to be taken, then queue its expected pixels.
	task automatic run_item(input mlr_pkg::op_t op, input int sx, input int sy, input int ex,
			input int ey, input exp_mode_t mode, input pixel_rec_t typed);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {CB'(ey), CB'(ex), CB'(sy), CB'(sx)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == mlr_pkg::OP_BEGIN || line_on) items_used++;
		rasterize_item(op, sx, sy, ex, ey);
		case (mode)
			EXP_MODEL: foreach (step_out[k]) pixel_q.push_back(step_out[k]);
			EXP_ONE:   pixel_q.push_back(typed);
			default: ;
		endcase
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		// idle steps leave nothing in the queue but may still be in flight
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_thick(input bit v);
		settle();
		thick_mode_we    <= 1'b1;
		thick_mode_wdata <= v;
		@(posedge clk);
		thick_mode_we <= 1'b0;
		thick_on = v;
		thick_writes++;
	endtask

	task automatic random_line(input bit well_formed);
		int sx, sy, ex, ey, span;
		sx = rand_coord();
		sy = rand_coord();
		if (well_formed) begin
			span = ($urandom_range(0, 9) == 0) ? 60 : 12;
			ex = near_coord(sx, span);
			ey = near_coord(sy, span);
		end else begin
			ex = rand_coord();
			ey = rand_coord();
		end
		run_item(mlr_pkg::OP_BEGIN, sx, sy, ex, ey, EXP_MODEL, '0);
		if (well_formed) begin
			while (line_on)
				run_item(mlr_pkg::OP_STEP, rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), EXP_MODEL, '0);
		end else begin
			// cut short; the next begin drops it
			repeat ($urandom_range(0, 6))
				run_item(mlr_pkg::OP_STEP, rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), EXP_MODEL, '0);
		end
	endtask

	// Result side: check each transfer, stall at random, one long hold.
	initial begin : pixel_sink
		pixel_rec_t    want;
		mlr_pkg::pix_t gx, gy;
		int            stall_left, quiet_left;
		bit            held, quiet;
		stall_left = 0;
		quiet_left = 0;
		held       = 0;
		quiet      = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				gx = m_tdata[mlr_pkg::PIX_BITS-1:0];
				gy = m_tdata[2*mlr_pkg::PIX_BITS-1:mlr_pkg::PIX_BITS];
				if (pixel_q.size() == 0) begin
					report_mismatch("pixel with nothing pending, x", gx, 0);
				end else begin
					want = pixel_q.pop_front();
					results_checked++;
					if (gx !== want.x) report_mismatch("pixel_x", gx, want.x);
					if (gy !== want.y) report_mismatch("pixel_y", gy, want.y);
					if (m_tuser[1:0] !== want.kind)
						report_mismatch("pixel_kind", m_tuser[1:0], want.kind);
					if (m_tuser[2] !== want.done)
						report_mismatch("line_done", m_tuser[2], want.done);
					if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
				end
			end
			if (quiet_left == 0) begin
				quiet = $urandom_range(0, 3) == 0;
				quiet_left = $urandom_range(50, 200);
			end else begin
				quiet_left--;
			end
			if (!held && results_checked >= 80) begin
				held = 1;
				stall_left = SINK_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!tail_phase && !quiet && $urandom_range(0, 99) < 25) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) :
					$urandom_range(1, 3);
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : line_source
		pixel_rec_t typed;
		int         goal, pick;
		thick_on = 1'b0;
		line_on  = 1'b0;
		cur_x = 0; cur_y = 0; dst_x = 0; dst_y = 0;
		dec = 0; inc_str = 0; inc_dia = 0;
		slope = mlr_pkg::SLOPE_SHALLOW_UP;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].act)
				ROW_THICK_ON:  write_thick(1'b1);
				ROW_THICK_OFF: write_thick(1'b0);
				default: begin
					typed.x    = mlr_pkg::pix_t'(dir_rows[i].tx);
					typed.y    = mlr_pkg::pix_t'(dir_rows[i].ty);
					typed.kind = dir_rows[i].tk;
					typed.last = 1'b1;
					typed.done = dir_rows[i].tk == mlr_pkg::KIND_END;
					run_item(dir_rows[i].op, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
						dir_rows[i].ey, dir_rows[i].mode, typed);
				end
			endcase
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			write_thick(ph == 0 ? 1'b1 : ph == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
			goal = items_used + PHASE_ITEMS;
			while (items_used < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					run_item(mlr_pkg::OP_STEP, rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), EXP_MODEL, '0);
				else if (pick < 25)
					random_line(1'b0);
				else
					random_line(1'b1);
			end
		end

		tail_phase = 1;
		settle();
		$display("covered %0d working transfers over %0d lines, %0d pixels checked",
			items_used, lines_begun, results_checked);
		$display("thick mode written %0d times, output held off once for %0d cycles",
			thick_writes, SINK_HOLD);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/mlr_pkg.sv
design/mlr_setup.sv
design/mlr_step.sv
design/midpoint_line_rasterizer_core.sv
tb/tb_midpoint_line_rasterizer_core.sv
